[rtl/ptrk_pkg.sv]
// ----------------------------------------------------------------------------
// ptrk_pkg
// Shared constants for the prefetch tracker: commands, reward types,
// configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package ptrk_pkg;

  localparam int unsigned TrackerDepth = 256;
  localparam int unsigned ActionBits   = 4;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 8;

  typedef enum logic [1:0] {
    CMD_TRACK  = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_DEMAND = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RT_TIMELY = 2'd0,
    RT_WRONG  = 2'd1,
    RT_OOB    = 2'd2
  } rtype_e;

  localparam logic [CfgIdxW-1:0] CFG_TIMELY     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_TIMELY_HBW = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_WRONG      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_WRONG_HBW  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_OOB        = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OOB_HBW    = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_OOB_EN     = 3'd6;

  localparam logic [7:0] RstTimely    = 8'sd20;
  localparam logic [7:0] RstTimelyHbw = 8'sd20;
  localparam logic [7:0] RstWrong     = 8'hF8;
  localparam logic [7:0] RstWrongHbw  = 8'hF2;
  localparam logic [7:0] RstOob       = 8'hF4;
  localparam logic [7:0] RstOobHbw    = 8'hF4;

endpackage

[rtl/prefetch_tracker_reward.sv]
// ----------------------------------------------------------------------------
// prefetch_tracker_reward
// FIFO tracker of issued prefetches with reward assignment and learn events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one command per transfer:
//   track, fill or demand, with an address and the track payload. Output
//   channel (out_valid_o / out_stall_i) returns exactly one result per
//   command. Config port (cfg_we_i, cfg_idx_i, cfg_data_i) writes the reward
//   registers; write only while the block is idle.
//   Entries live in a single-port-read, single-port-write RAM. The oldest
//   matching entry is found by scanning from the FIFO head, one entry per
//   cycle, then the entry is modified and written back in the resolve state.
//   An empty tracker or the unused command skips the scan; a miss examines
//   every filled entry.
//   One command is in flight at a time; the next is taken in the cycle after
//   the result is registered.
//   A result waiting in the output register does not block the next input;
//   only the resolve step waits while the receiver stalls.
//   Reset empties the FIFO and clears the evicted entry; RAM contents are
//   not cleared, no clearing pass is needed.
// ----------------------------------------------------------------------------
module prefetch_tracker_reward #(
  parameter int unsigned TRACKER_DEPTH = ptrk_pkg::TrackerDepth,
  parameter int unsigned ACTION_BITS   = ptrk_pkg::ActionBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // config
  input  logic                          cfg_we_i,
  input  logic [ptrk_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ptrk_pkg::CfgDataW-1:0] cfg_data_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [47:0]                   address_i,
  input  logic [15:0]                   state_id_i,
  input  logic [35:0]                   state_page_i,
  input  logic                          state_high_bw_i,
  input  logic [3:0]                    action_index_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          accepted_o,
  output logic [7:0]                    tracker_slot_o,
  output logic                          hit_o,
  output logic                          learn_valid_o,
  output logic [15:0]                   prev_state_id_o,
  output logic [3:0]                    prev_action_o,
  output logic signed [7:0]             prev_reward_o,
  output logic [1:0]                    prev_reward_type_o,
  output logic [15:0]                   cur_state_id_o,
  output logic [3:0]                    cur_action_o
);

  localparam int unsigned PW = (TRACKER_DEPTH > 1) ? $clog2(TRACKER_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TRACKER_DEPTH + 1);
  localparam int unsigned AB = ACTION_BITS;

  typedef struct packed {
    logic [47:0]   addr;
    logic [15:0]   sid;
    logic [35:0]   page;
    logic          hbw;
    logic [AB-1:0] act;
    logic          filled;
    logic          rewarded;
    logic [7:0]    rew;
    logic [1:0]    rtype;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_SCAN    = 3'b010,
    S_RESOLVE = 3'b100
  } state_e;

  // ---------------------------------------------------------------- config
  logic [7:0] cfg_timely_q, cfg_timely_hbw_q, cfg_wrong_q, cfg_wrong_hbw_q;
  logic [7:0] cfg_oob_q, cfg_oob_hbw_q;
  logic       cfg_oob_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_timely_q     <= ptrk_pkg::RstTimely;
      cfg_timely_hbw_q <= ptrk_pkg::RstTimelyHbw;
      cfg_wrong_q      <= ptrk_pkg::RstWrong;
      cfg_wrong_hbw_q  <= ptrk_pkg::RstWrongHbw;
      cfg_oob_q        <= ptrk_pkg::RstOob;
      cfg_oob_hbw_q    <= ptrk_pkg::RstOobHbw;
      cfg_oob_en_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ptrk_pkg::CFG_TIMELY:     cfg_timely_q     <= cfg_data_i;
        ptrk_pkg::CFG_TIMELY_HBW: cfg_timely_hbw_q <= cfg_data_i;
        ptrk_pkg::CFG_WRONG:      cfg_wrong_q      <= cfg_data_i;
        ptrk_pkg::CFG_WRONG_HBW:  cfg_wrong_hbw_q  <= cfg_data_i;
        ptrk_pkg::CFG_OOB:        cfg_oob_q        <= cfg_data_i;
        ptrk_pkg::CFG_OOB_HBW:    cfg_oob_hbw_q    <= cfg_data_i;
        ptrk_pkg::CFG_OOB_EN:     cfg_oob_en_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- entry RAM
  entry_t          mem [TRACKER_DEPTH];
  entry_t          rdata_q;
  logic   [PW-1:0] raddr;
  logic            we;
  logic   [PW-1:0] waddr;
  entry_t          wdata;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // ---------------------------------------------------------------- control
  state_e          state_q, state_d;
  logic   [1:0]    cmd_q;
  logic   [47:0]   addr_q;
  logic   [15:0]   sid_q;
  logic   [35:0]   page_q;
  logic            hbw_q;
  logic   [AB-1:0] act_q;

  logic   [PW-1:0] ptr_q, ptr_d;
  logic   [CW-1:0] idx_q, idx_d;
  logic            found_q, found_d;
  logic   [PW-1:0] slot_q, slot_d;
  entry_t          entry_q, entry_d;
  entry_t          oldest_q, oldest_d;

  logic   [PW-1:0] head_q, head_d;
  logic   [CW-1:0] count_q, count_d;
  logic            ev_valid_q, ev_valid_d;
  logic            ev_rewarded_q, ev_rewarded_d;
  logic   [15:0]   ev_sid_q, ev_sid_d;
  logic   [AB-1:0] ev_act_q, ev_act_d;
  logic   [7:0]    ev_rew_q, ev_rew_d;
  logic   [1:0]    ev_rtype_q, ev_rtype_d;

  // result register
  logic            out_valid_q, out_valid_d;
  logic            res_acc_q, res_acc_d;
  logic   [7:0]    res_slot_q, res_slot_d;
  logic            res_hit_q, res_hit_d;
  logic            res_learn_q, res_learn_d;
  logic   [15:0]   res_psid_q, res_psid_d;
  logic   [3:0]    res_pact_q, res_pact_d;
  logic   [7:0]    res_prew_q, res_prew_d;
  logic   [1:0]    res_ptype_q, res_ptype_d;
  logic   [15:0]   res_csid_q, res_csid_d;
  logic   [3:0]    res_cact_q, res_cact_d;

  logic            in_xfer;
  logic            out_free;
  logic [AB+3:0]   act_in_ext;
  logic [PW-1:0]   ptr_next;
  logic [PW:0]     tail_sum;
  logic [PW-1:0]   tail;
  logic            full;
  logic [PW+7:0]   slot_ext;
  logic [AB+3:0]   pact_ext;
  logic [AB+3:0]   cact_ext;
  logic [7:0]      r_main;
  logic [7:0]      r_oob;
  logic [7:0]      r_sel;
  logic [1:0]      t_sel;
  logic            do_reward;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign act_in_ext = {{AB{1'b0}}, action_index_i};
  assign ptr_next   = (ptr_q == PW'(TRACKER_DEPTH - 1)) ? '0 : ptr_q + 1'b1;
  assign full       = (count_q == CW'(TRACKER_DEPTH));
  assign tail_sum   = {1'b0, head_q} + {1'b0, count_q[PW-1:0]};
  assign tail       = (tail_sum >= (PW+1)'(TRACKER_DEPTH))
                    ? tail_sum[PW-1:0] - PW'(TRACKER_DEPTH) : tail_sum[PW-1:0];
  assign raddr      = ptr_d;

  // reward selection for the demand path
  always_comb begin
    if (entry_q.filled) begin
      r_main = entry_q.hbw ? cfg_timely_hbw_q : cfg_timely_q;
    end else begin
      r_main = entry_q.hbw ? cfg_wrong_hbw_q : cfg_wrong_q;
    end
    r_oob = entry_q.hbw ? cfg_oob_hbw_q : cfg_oob_q;
    if (r_main != 8'd0) begin
      do_reward = 1'b1;
      r_sel     = r_main;
      t_sel     = entry_q.filled ? ptrk_pkg::RT_TIMELY : ptrk_pkg::RT_WRONG;
    end else begin
      do_reward = cfg_oob_en_q && (entry_q.act == '0) && (r_oob != 8'd0);
      r_sel     = r_oob;
      t_sel     = ptrk_pkg::RT_OOB;
    end
  end

  assign pact_ext = {4'b0, ev_act_q};
  assign cact_ext = {4'b0, entry_q.act};

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    found_d     = found_q;
    slot_d      = slot_q;
    entry_d     = entry_q;
    oldest_d    = oldest_q;
    head_d      = head_q;
    count_d     = count_q;
    ev_valid_d    = ev_valid_q;
    ev_rewarded_d = ev_rewarded_q;
    ev_sid_d      = ev_sid_q;
    ev_act_d      = ev_act_q;
    ev_rew_d      = ev_rew_q;
    ev_rtype_d    = ev_rtype_q;
    we          = 1'b0;
    waddr       = slot_q;
    wdata       = entry_q;
    slot_ext    = '0;
    out_valid_d = out_valid_q && out_stall_i;
    res_acc_d   = res_acc_q;
    res_slot_d  = res_slot_q;
    res_hit_d   = res_hit_q;
    res_learn_d = res_learn_q;
    res_psid_d  = res_psid_q;
    res_pact_d  = res_pact_q;
    res_prew_d  = res_prew_q;
    res_ptype_d = res_ptype_q;
    res_csid_d  = res_csid_q;
    res_cact_d  = res_cact_q;

    unique case (state_q)
      S_IDLE: begin
        ptr_d = head_q;
        if (in_xfer) begin
          idx_d   = '0;
          found_d = 1'b0;
          if (command_i == ptrk_pkg::CMD_NONE || count_q == '0) begin
            state_d = S_RESOLVE;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (idx_q == '0) begin
          oldest_d = rdata_q;
        end
        if (rdata_q.addr == addr_q) begin
          found_d = 1'b1;
          slot_d  = ptr_q;
          entry_d = rdata_q;
          state_d = S_RESOLVE;
        end else if (idx_q + 1'b1 == count_q) begin
          state_d = S_RESOLVE;
        end else begin
          idx_d = idx_q + 1'b1;
          ptr_d = ptr_next;
        end
      end
      S_RESOLVE: begin
        if (out_free) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          res_acc_d   = 1'b0;
          res_slot_d  = '0;
          res_hit_d   = found_q;
          res_learn_d = 1'b0;
          res_psid_d  = '0;
          res_pact_d  = '0;
          res_prew_d  = '0;
          res_ptype_d = '0;
          res_csid_d  = '0;
          res_cact_d  = '0;
          unique case (cmd_q)
            ptrk_pkg::CMD_TRACK: begin
              if (found_q) begin
                if (entry_q.page == page_q) begin
                  we         = 1'b1;
                  waddr      = slot_q;
                  wdata      = entry_q;
                  wdata.sid  = sid_q;
                  wdata.page = page_q;
                  wdata.hbw  = hbw_q;
                  wdata.act  = act_q;
                  slot_ext   = {8'b0, slot_q};
                  res_acc_d  = 1'b1;
                  res_slot_d = slot_ext[7:0];
                end
              end else begin
                we             = 1'b1;
                wdata          = '0;
                wdata.addr     = addr_q;
                wdata.sid      = sid_q;
                wdata.page     = page_q;
                wdata.hbw      = hbw_q;
                wdata.act      = act_q;
                if (full) begin
                  // oldest entry leaves; new one takes its slot
                  waddr         = head_q;
                  head_d        = (head_q == PW'(TRACKER_DEPTH - 1)) ? '0 : head_q + 1'b1;
                  ev_valid_d    = 1'b1;
                  ev_rewarded_d = oldest_q.rewarded;
                  ev_sid_d      = oldest_q.sid;
                  ev_act_d      = oldest_q.act;
                  ev_rew_d      = oldest_q.rew;
                  ev_rtype_d    = oldest_q.rtype;
                end else begin
                  waddr   = tail;
                  count_d = count_q + 1'b1;
                end
                slot_ext   = {8'b0, waddr};
                res_acc_d  = 1'b1;
                res_slot_d = slot_ext[7:0];
              end
            end
            ptrk_pkg::CMD_FILL: begin
              if (found_q) begin
                we           = 1'b1;
                wdata        = entry_q;
                wdata.filled = 1'b1;
                slot_ext     = {8'b0, slot_q};
                res_slot_d   = slot_ext[7:0];
              end
            end
            ptrk_pkg::CMD_DEMAND: begin
              if (found_q) begin
                slot_ext   = {8'b0, slot_q};
                res_slot_d = slot_ext[7:0];
                if (!entry_q.rewarded && do_reward) begin
                  we             = 1'b1;
                  wdata          = entry_q;
                  wdata.rewarded = 1'b1;
                  wdata.rew      = r_sel;
                  wdata.rtype    = t_sel;
                  if (ev_valid_q && ev_rewarded_q) begin
                    res_learn_d = 1'b1;
                    res_psid_d  = ev_sid_q;
                    res_pact_d  = pact_ext[3:0];
                    res_prew_d  = ev_rew_q;
                    res_ptype_d = ev_rtype_q;
                    res_csid_d  = entry_q.sid;
                    res_cact_d  = cact_ext[3:0];
                  end
                end
              end
            end
            default: begin
              res_hit_d = 1'b0;
            end
          endcase
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q  <= command_i;
      addr_q <= address_i;
      sid_q  <= state_id_i;
      page_q <= state_page_i;
      hbw_q  <= state_high_bw_i;
      act_q  <= act_in_ext[AB-1:0];
    end
    ptr_q       <= ptr_d;
    idx_q       <= idx_d;
    slot_q      <= slot_d;
    entry_q     <= entry_d;
    oldest_q    <= oldest_d;
    res_acc_q   <= res_acc_d;
    res_slot_q  <= res_slot_d;
    res_hit_q   <= res_hit_d;
    res_learn_q <= res_learn_d;
    res_psid_q  <= res_psid_d;
    res_pact_q  <= res_pact_d;
    res_prew_q  <= res_prew_d;
    res_ptype_q <= res_ptype_d;
    res_csid_q  <= res_csid_d;
    res_cact_q  <= res_cact_d;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      found_q       <= 1'b0;
      head_q        <= '0;
      count_q       <= '0;
      ev_valid_q    <= 1'b0;
      ev_rewarded_q <= 1'b0;
      ev_sid_q      <= '0;
      ev_act_q      <= '0;
      ev_rew_q      <= '0;
      ev_rtype_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      found_q       <= found_d;
      head_q        <= head_d;
      count_q       <= count_d;
      ev_valid_q    <= ev_valid_d;
      ev_rewarded_q <= ev_rewarded_d;
      ev_sid_q      <= ev_sid_d;
      ev_act_q      <= ev_act_d;
      ev_rew_q      <= ev_rew_d;
      ev_rtype_q    <= ev_rtype_d;
      out_valid_q   <= out_valid_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign accepted_o         = res_acc_q;
  assign tracker_slot_o     = res_slot_q;
  assign hit_o              = res_hit_q;
  assign learn_valid_o      = res_learn_q;
  assign prev_state_id_o    = res_psid_q;
  assign prev_action_o      = res_pact_q;
  assign prev_reward_o      = res_prew_q;
  assign prev_reward_type_o = res_ptype_q;
  assign cur_state_id_o     = res_csid_q;
  assign cur_action_o       = res_cact_q;

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for prefetch_tracker_reward: a directed table, then
// random traffic on a reused address pool that fills the tracker, forces
// evictions and learn events, checked against an in-bench tracker model.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned Depth      = ptrk_pkg::TrackerDepth;
  localparam int unsigned PoolSize   = 300;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned PhaseItems = 215;
  localparam int unsigned IdleLimit  = 20000;
  localparam int unsigned NumDir     = 13;

  typedef struct packed {
    ptrk_pkg::cmd_e cmd;
    logic [47:0]    addr;
    logic [15:0]    sid;
    logic [35:0]    page;
    logic           hbw;
    logic [3:0]     act;
  } cmd_item_t;

  typedef struct packed {
    logic        accepted;
    logic [7:0]  slot;
    logic        hit;
    logic        learn;
    logic [15:0] prev_sid;
    logic [3:0]  prev_act;
    logic [7:0]  prev_rew;
    logic [1:0]  prev_rtype;
    logic [15:0] cur_sid;
    logic [3:0]  cur_act;
  } outcome_t;

  typedef struct packed {
    logic [47:0]      addr;
    logic [15:0]      sid;
    logic [35:0]      page;
    logic             hbw;
    logic [3:0]       act;
    logic             filled;
    logic             rewarded;
    logic [7:0]       rew;
    ptrk_pkg::rtype_e rtype;
  } track_entry_t;

  typedef struct packed {
    cmd_item_t item;
    logic      typed;
    outcome_t  want;
  } dir_row_t;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [ptrk_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [ptrk_pkg::CfgDataW-1:0] cfg_data_i;
  logic in_valid_i, in_stall_o;
  logic [1:0]  command_i;
  logic [47:0] address_i;
  logic [15:0] state_id_i;
  logic [35:0] state_page_i;
  logic        state_high_bw_i;
  logic [3:0]  action_index_i;
  logic out_valid_o, out_stall_i;
  logic accepted_o, hit_o, learn_valid_o;
  logic [7:0]  tracker_slot_o;
  logic [15:0] prev_state_id_o, cur_state_id_o;
  logic [3:0]  prev_action_o, cur_action_o;
  logic signed [7:0] prev_reward_o;
  logic [1:0]  prev_reward_type_o;

  prefetch_tracker_reward dut (.*);

  // 8 ns clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Tracker model: FIFO of entries plus the last evicted one
  // ---------------------------------------------------------------------------
  track_entry_t trk[Depth];
  int unsigned  trk_head, trk_cnt;
  track_entry_t evicted;
  logic         evicted_vld;
  logic [7:0]   rw_timely, rw_timely_hbw, rw_wrong, rw_wrong_hbw, rw_oob, rw_oob_hbw;
  logic         oob_en;

  outcome_t    pending_q[$];
  int unsigned n_sent, n_recv, n_err, n_learn, n_evict, n_refused;
  int unsigned snd_pct, rcv_pct, idle_cyc;
  logic [47:0] pool_addr[PoolSize];
  logic [35:0] pool_page[PoolSize];

  // Apply a reward; emit a learn event only when the evicted entry was rewarded.
  function automatic void grant(int unsigned s, logic [7:0] r, ptrk_pkg::rtype_e t,
                                ref outcome_t o);
    trk[s].rew      = r;
    trk[s].rewarded = 1'b1;
    trk[s].rtype    = t;
    if (evicted_vld && evicted.rewarded) begin
      o.learn      = 1'b1;
      o.prev_sid   = evicted.sid;
      o.prev_act   = evicted.act;
      o.prev_rew   = evicted.rew;
      o.prev_rtype = evicted.rtype;
      o.cur_sid    = trk[s].sid;
      o.cur_act    = trk[s].act;
    end
  endfunction

  function automatic outcome_t track_outcome(cmd_item_t it);
    outcome_t    o;
    int unsigned s, i;
    logic        found;
    logic [7:0]  r;
    o     = '0;
    s     = 0;
    found = 1'b0;
    if (it.cmd == ptrk_pkg::CMD_NONE) return o;
    // oldest match wins
    for (i = 0; i < trk_cnt; i++) begin
      if (!found && trk[(trk_head + i) % Depth].addr == it.addr) begin
        found = 1'b1;
        s     = (trk_head + i) % Depth;
      end
    end
    o.hit = found;
    if (it.cmd == ptrk_pkg::CMD_TRACK) begin
      if (found) begin
        if (trk[s].page != it.page) begin
          n_refused++;
          return o;
        end
        trk[s].sid  = it.sid;
        trk[s].hbw  = it.hbw;
        trk[s].act  = it.act;
      end else begin
        if (trk_cnt >= Depth) begin
          evicted     = trk[trk_head];
          evicted_vld = 1'b1;
          trk_head    = (trk_head + 1) % Depth;
          trk_cnt--;
          n_evict++;
        end
        s = (trk_head + trk_cnt) % Depth;
        trk_cnt++;
        trk[s]      = '0;
        trk[s].addr = it.addr;
        trk[s].sid  = it.sid;
        trk[s].page = it.page;
        trk[s].hbw  = it.hbw;
        trk[s].act  = it.act;
      end
      o.accepted = 1'b1;
      o.slot     = s[7:0];
      return o;
    end
    if (!found) return o;
    o.slot = s[7:0];
    if (it.cmd == ptrk_pkg::CMD_FILL) begin
      trk[s].filled = 1'b1;
      return o;
    end
    if (trk[s].rewarded) return o;
    // zero reward falls through to the out-of-bounds check
    if (trk[s].filled) begin
      r = trk[s].hbw ? rw_timely_hbw : rw_timely;
      if (r != 0) begin
        grant(s, r, ptrk_pkg::RT_TIMELY, o);
        return o;
      end
    end else begin
      r = trk[s].hbw ? rw_wrong_hbw : rw_wrong;
      if (r != 0) begin
        grant(s, r, ptrk_pkg::RT_WRONG, o);
        return o;
      end
    end
    if (oob_en && trk[s].act == 0) begin
      r = trk[s].hbw ? rw_oob_hbw : rw_oob;
      if (r != 0) grant(s, r, ptrk_pkg::RT_OOB, o);
    end
    return o;
  endfunction

  function automatic string show(outcome_t o);
    return $sformatf("acc=%0d slot=%0d hit=%0d lrn=%0d prev=%h/%h/%h/%0d cur=%h/%h",
                     o.accepted, o.slot, o.hit, o.learn, o.prev_sid, o.prev_act,
                     o.prev_rew, o.prev_rtype, o.cur_sid, o.cur_act);
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: random stall, scoreboard, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    outcome_t got, want;
    got = '{accepted_o, tracker_slot_o, hit_o, learn_valid_o, prev_state_id_o,
            prev_action_o, prev_reward_o, prev_reward_type_o, cur_state_id_o,
            cur_action_o};
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_recv++;
      if (got.learn) n_learn++;
      if (pending_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("ERROR: result with nothing pending: %s", show(got));
      end else begin
        want = pending_q[0];
        pending_q.delete(0);
        if (got !== want) begin
          n_err++;
          if (n_err <= 10)
            $display("ERROR: result %0d\n  exp %s\n  got %s", n_recv, show(want), show(got));
        end
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cyc = 0;
    else idle_cyc++;
    if (idle_cyc > IdleLimit) begin
      $display("watchdog: no transfer for %0d cycles, %0d results pending",
               idle_cyc, pending_q.size());
      $display("FAIL prefetch_tracker_reward");
      $finish;
    end
    out_stall_i <= ($urandom_range(99) < rcv_pct);
  end

  // ---------------------------------------------------------------------------
  // Command side
  // ---------------------------------------------------------------------------
  task automatic send(input cmd_item_t it, input logic typed, input outcome_t want);
    outcome_t p;
    if ($urandom_range(99) < snd_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    command_i       <= it.cmd;
    address_i       <= it.addr;
    state_id_i      <= it.sid;
    state_page_i    <= it.page;
    state_high_bw_i <= it.hbw;
    action_index_i  <= it.act;
    do @(posedge clk_i); while (in_stall_o);
    p = track_outcome(it);
    pending_q.insert(pending_q.size(), typed ? want : p);
    n_sent++;
  endtask

  // Let the tracker drain before touching registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_q.size() != 0) @(posedge clk_i);
  endtask

  // Write enable stays high across back-to-back writes; set_rewards drops it.
  task automatic wr_reg(input logic [ptrk_pkg::CfgIdxW-1:0] idx, input logic [7:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
  endtask

  task automatic set_rewards(input logic [7:0] t, th, w, wh, o, oh, input logic en);
    wr_reg(ptrk_pkg::CFG_TIMELY, t);
    wr_reg(ptrk_pkg::CFG_TIMELY_HBW, th);
    wr_reg(ptrk_pkg::CFG_WRONG, w);
    wr_reg(ptrk_pkg::CFG_WRONG_HBW, wh);
    wr_reg(ptrk_pkg::CFG_OOB, o);
    wr_reg(ptrk_pkg::CFG_OOB_HBW, oh);
    wr_reg(ptrk_pkg::CFG_OOB_EN, {7'd0, en});
    cfg_we_i <= 1'b0;
    rw_timely = t; rw_timely_hbw = th; rw_wrong = w; rw_wrong_hbw = wh;
    rw_oob = o; rw_oob_hbw = oh; oob_en = en;
  endtask

  // Mostly pool traffic so entries get filled, demanded and evicted; some noise.
  function automatic cmd_item_t rand_item();
    cmd_item_t   it;
    int unsigned k, pick;
    k    = $urandom_range(PoolSize - 1);
    pick = $urandom_range(99);
    it.cmd  = (pick < 42) ? ptrk_pkg::CMD_TRACK : (pick < 67) ? ptrk_pkg::CMD_FILL :
              (pick < 95) ? ptrk_pkg::CMD_DEMAND : ptrk_pkg::CMD_NONE;
    it.addr = ($urandom_range(99) < 92) ? pool_addr[k] : 48'({$urandom, $urandom});
    it.page = ($urandom_range(99) < 90) ? pool_page[k] : 36'({$urandom, $urandom});
    it.sid  = 16'($urandom);
    it.hbw  = 1'($urandom_range(1));
    it.act  = ($urandom_range(99) < 30) ? 4'd0 : 4'($urandom);
    return it;
  endfunction

  function automatic dir_row_t row(ptrk_pkg::cmd_e c, logic [47:0] a, logic [15:0] sid,
                                   logic [35:0] pg, logic hb, logic [3:0] act,
                                   logic typed, logic acc, logic [7:0] sl, logic h);
    dir_row_t d;
    d.item  = '{c, a, sid, pg, hb, act};
    d.typed = typed;
    d.want  = '0;
    d.want.accepted = acc;
    d.want.slot     = sl;
    d.want.hit      = h;
    return d;
  endfunction

  localparam logic [47:0] AddrHi  = '1;
  localparam logic [47:0] AddrLo  = '0;
  localparam logic [47:0] AddrAlt = 48'h5555_AAAA_5555;
  localparam logic [35:0] PageHi  = '1;

  initial begin
    dir_row_t    dir_tab[NumDir];
    cmd_item_t   it;
    int unsigned ph, i;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; command_i = '0; address_i = '0; state_id_i = '0;
    state_page_i = '0; state_high_bw_i = 1'b0; action_index_i = '0;
    out_stall_i = 1'b0;
    rst_ni = 1'b0;
    trk_head = 0; trk_cnt = 0; evicted = '0; evicted_vld = 1'b0;
    rw_timely = ptrk_pkg::RstTimely; rw_timely_hbw = ptrk_pkg::RstTimelyHbw;
    rw_wrong = ptrk_pkg::RstWrong; rw_wrong_hbw = ptrk_pkg::RstWrongHbw;
    rw_oob = ptrk_pkg::RstOob; rw_oob_hbw = ptrk_pkg::RstOobHbw; oob_en = 1'b0;
    n_sent = 0; n_recv = 0; n_err = 0; n_learn = 0; n_evict = 0; n_refused = 0;
    idle_cyc = 0;
    snd_pct = 23; rcv_pct = 83;
    for (i = 0; i < PoolSize; i++) begin
      pool_addr[i] = 48'({$urandom, $urandom});
      pool_page[i] = 36'({$urandom, $urandom});
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset register values, empty tracker, refusal, update,
    // timely and wrong rewards, repeat demand, misses, idle command.
    dir_tab[0]  = row(ptrk_pkg::CMD_DEMAND, AddrHi, '0, '0, 1'b0, 4'd0,
                      1'b1, 1'b0, 8'd0, 1'b0);
    dir_tab[1]  = row(ptrk_pkg::CMD_NONE, AddrHi, '1, PageHi, 1'b1, '1,
                      1'b1, 1'b0, 8'd0, 1'b0);
    dir_tab[2]  = row(ptrk_pkg::CMD_TRACK, AddrHi, '1, PageHi, 1'b1, '1,
                      1'b1, 1'b1, 8'd0, 1'b0);
    dir_tab[3]  = row(ptrk_pkg::CMD_TRACK, AddrLo, '0, '0, 1'b0, 4'd0,
                      1'b1, 1'b1, 8'd1, 1'b0);
    dir_tab[4]  = row(ptrk_pkg::CMD_TRACK, AddrHi, 16'h1234, '0, 1'b0, 4'd0,
                      1'b1, 1'b0, 8'd0, 1'b1);
    dir_tab[5]  = row(ptrk_pkg::CMD_TRACK, AddrHi, 16'h1234, PageHi, 1'b0, 4'd0,
                      1'b1, 1'b1, 8'd0, 1'b1);
    dir_tab[6]  = row(ptrk_pkg::CMD_FILL, AddrHi, '0, '0, 1'b0, 4'd0,
                      1'b1, 1'b0, 8'd0, 1'b1);
    dir_tab[7]  = row(ptrk_pkg::CMD_DEMAND, AddrHi, '0, '0, 1'b0, 4'd0,
                      1'b1, 1'b0, 8'd0, 1'b1);
    dir_tab[8]  = row(ptrk_pkg::CMD_DEMAND, AddrHi, '0, '0, 1'b0, 4'd0,
                      1'b1, 1'b0, 8'd0, 1'b1);
    dir_tab[9]  = row(ptrk_pkg::CMD_DEMAND, AddrLo, '0, '0, 1'b0, 4'd0,
                      1'b1, 1'b0, 8'd1, 1'b1);
    dir_tab[10] = row(ptrk_pkg::CMD_FILL, AddrAlt, '0, '0, 1'b0, 4'd0,
                      1'b1, 1'b0, 8'd0, 1'b0);
    dir_tab[11] = row(ptrk_pkg::CMD_TRACK, AddrAlt, 16'hA5A5, 36'h9_0F0F_0F0F, 1'b1, 4'd0,
                      1'b0, 1'b0, 8'd0, 1'b0);
    dir_tab[12] = row(ptrk_pkg::CMD_DEMAND, AddrAlt, '0, '0, 1'b0, 4'd0,
                      1'b0, 1'b0, 8'd0, 1'b0);
    for (i = 0; i < NumDir; i++) send(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);

    // Random phases, each under its own reward setting; the idle pattern changes every two phases.
    for (ph = 0; ph < NumPhases; ph++) begin
      drain();
      snd_pct = (ph < 2) ? 23 : (ph < 4) ? 83 : 0;
      rcv_pct = (ph < 2) ? 83 : (ph < 4) ? 23 : 0;
      case (ph)
        1: set_rewards(8'sd127, -8'sd128, 8'd0, 8'sd127, -8'sd128, 8'sd127, 1'b1);
        3: set_rewards(8'd0, 8'd0, -8'sd128, 8'd0, 8'd0, -8'sd1, 1'b1);
        0: ;
        default: set_rewards(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                             8'($urandom), 8'($urandom), ph != 5);
      endcase
      for (i = 0; i < PhaseItems; i++) begin
        if (i == 50) drain();  // hold off until the tracker has answered everything
        it = rand_item();
        send(it, 1'b0, '0);
      end
    end

    drain();
    repeat (300) @(posedge clk_i);
    $display("covered %0d commands, %0d results, %0d evictions, %0d learn events,",
             n_sent, n_recv, n_evict, n_learn);
    $display("%0d page refusals over %0d reward settings; %0d mismatches",
             n_refused, NumPhases, n_err);
    if (n_err == 0 && pending_q.size() == 0) begin
      $display("PASS prefetch_tracker_reward");
    end else begin
      $display("FAIL prefetch_tracker_reward");
    end
    $finish;
  end

endmodule
